// ----- rtl/core/ppi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_pkg
// Item types for the three point parabolic peak interpolation core.
// ----------------------------------------------------------------------------
package ppi_pkg;

   localparam int unsigned FracBits = 16;

   typedef struct packed {
      logic signed [31:0] value_a;
      logic signed [31:0] value_b;
      logic signed [31:0] value_c;
      logic signed [15:0] position_a;
      logic signed [15:0] position_b;
      logic signed [15:0] position_c;
   } req_type;

   typedef struct packed {
      logic signed [31:0] peak_position;
      logic               degenerate;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/core/parabolic_peak_interpolation_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// parabolic_peak_interpolation_core
// Fits a parabola through three samples and returns its vertex position with
// 16 fraction bits, rounded toward zero and saturated.
// ----------------------------------------------------------------------------
// One item is accepted every cycle (busy is always low) and its result leaves
// as a one cycle rsp_valid strobe after five stages of difference, multiply,
// sum, magnitude and range check, then a restoring divider that settles one
// quotient bit per stage over 32 stages, then the output register. Results
// come out in the order the items went in; the receiver cannot stall.
module parabolic_peak_interpolation_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire ppi_pkg::req_type req_data,
   output logic                  rsp_valid,
   output ppi_pkg::rsp_type      rsp_data
);
   import ppi_pkg::*;

   localparam int QuotBits = 32;
   localparam int RemBits  = 80;

   typedef struct packed {
      logic [48:0]        ma;
      logic [RemBits-1:0] rem;
      logic [31:0]        quot;
      logic               neg;
      logic               ovf;
      logic               deg;
   } div_type;

   // stage 1: differences, squares, coincidence check
   logic               s1_valid_ff;
   logic signed [32:0] s1_da_ff, s1_db_ff, s1_dc_ff;
   logic signed [15:0] s1_x1_ff, s1_x2_ff, s1_x3_ff;
   logic signed [31:0] s1_q1_ff, s1_q2_ff, s1_q3_ff;
   logic               s1_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      s1_da_ff  <= 33'(req_data.value_b) - 33'(req_data.value_a);
      s1_db_ff  <= 33'(req_data.value_a) - 33'(req_data.value_c);
      s1_dc_ff  <= 33'(req_data.value_c) - 33'(req_data.value_b);
      s1_x1_ff  <= req_data.position_a;
      s1_x2_ff  <= req_data.position_b;
      s1_x3_ff  <= req_data.position_c;
      s1_q1_ff  <= 32'(req_data.position_a) * 32'(req_data.position_a);
      s1_q2_ff  <= 32'(req_data.position_b) * 32'(req_data.position_b);
      s1_q3_ff  <= 32'(req_data.position_c) * 32'(req_data.position_c);
      s1_deg_ff <= (req_data.position_a == req_data.position_b) ||
                   (req_data.position_a == req_data.position_c) ||
                   (req_data.position_b == req_data.position_c);
   end

   // stage 2: products of positions and differences
   logic               s2_valid_ff;
   logic signed [48:0] s2_pa_ff, s2_pb_ff, s2_pc_ff;
   logic signed [64:0] s2_ra_ff, s2_rb_ff, s2_rc_ff;
   logic               s2_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_pa_ff  <= 49'(s1_x3_ff) * 49'(s1_da_ff);
      s2_pb_ff  <= 49'(s1_x2_ff) * 49'(s1_db_ff);
      s2_pc_ff  <= 49'(s1_x1_ff) * 49'(s1_dc_ff);
      s2_ra_ff  <= 65'(s1_q3_ff) * 65'(s1_da_ff);
      s2_rb_ff  <= 65'(s1_q2_ff) * 65'(s1_db_ff);
      s2_rc_ff  <= 65'(s1_q1_ff) * 65'(s1_dc_ff);
      s2_deg_ff <= s1_deg_ff;
   end

   // stage 3: sums, the b sum is kept negated
   logic               s3_valid_ff;
   logic signed [50:0] s3_na_ff;
   logic signed [66:0] s3_nbn_ff;
   logic               s3_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_na_ff  <= 51'(s2_pa_ff) + 51'(s2_pb_ff) + 51'(s2_pc_ff);
      s3_nbn_ff <= 67'(s2_ra_ff) + 67'(s2_rb_ff) + 67'(s2_rc_ff);
      s3_deg_ff <= s2_deg_ff;
   end

   // stage 4: magnitudes and signs, flat parabola check
   logic        s4_valid_ff;
   logic [48:0] s4_ma_ff;
   logic [63:0] s4_mb_ff;
   logic        s4_neg_ff;
   logic        s4_deg_ff;
   logic [50:0] s4_ma_in;
   logic [66:0] s4_mb_in;

   always_comb begin
      s4_ma_in = s3_na_ff[50] ? 51'(-s3_na_ff) : 51'(s3_na_ff);
      s4_mb_in = s3_nbn_ff[66] ? 67'(-s3_nbn_ff) : 67'(s3_nbn_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_ma_ff  <= s4_ma_in[48:0];
      s4_mb_ff  <= s4_mb_in[63:0];
      // b is the negated sum, so equal signs of a and b mean differing here
      s4_neg_ff <= (s3_nbn_ff != '0) && (s3_na_ff[50] != s3_nbn_ff[66]);
      s4_deg_ff <= s3_deg_ff || (s3_na_ff == '0);
   end

   // stage 5: quotient range check and divider load
   div_type dv_ff [0:QuotBits];
   logic    dv_valid_ff [0:QuotBits];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= s4_valid_ff;
      end
      dv_ff[0].ma   <= s4_ma_ff;
      dv_ff[0].rem  <= RemBits'(s4_mb_ff) << (FracBits - 1);
      dv_ff[0].quot <= '0;
      dv_ff[0].neg  <= s4_neg_ff;
      dv_ff[0].ovf  <= 66'(s4_mb_ff) >= (66'(s4_ma_ff) << (QuotBits - FracBits + 1));
      dv_ff[0].deg  <= s4_deg_ff;
   end

   // restoring divider, one quotient bit per stage from the top
   for (genvar k = 0; k < QuotBits; k++) begin : g_div
      localparam int Bit = QuotBits - 1 - k;
      logic [RemBits-1:0] dsr;
      logic               fits;
      div_type            nxt;

      always_comb begin
         dsr  = RemBits'(dv_ff[k].ma) << Bit;
         fits = dv_ff[k].rem >= dsr;
         nxt  = dv_ff[k];
         if (fits) begin
            nxt.rem       = dv_ff[k].rem - dsr;
            nxt.quot[Bit] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
         dv_ff[k+1] <= nxt;
      end
   end

   // output stage: sign, saturation, degenerate case
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   div_type dv_last;

   always_comb begin
      dv_last = dv_ff[QuotBits];
      rsp_data_in.degenerate = 1'b0;
      priority if (dv_last.deg) begin
         rsp_data_in.peak_position = '0;
         rsp_data_in.degenerate    = 1'b1;
      end else if (dv_last.ovf) begin
         rsp_data_in.peak_position = dv_last.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (dv_last.neg) begin
         rsp_data_in.peak_position = (dv_last.quot > 32'h8000_0000) ?
                                     32'sh8000_0000 : $signed(32'(-dv_last.quot));
      end else begin
         rsp_data_in.peak_position = dv_last.quot[31] ?
                                     32'sh7FFF_FFFF : $signed(dv_last.quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid_ff[QuotBits];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
